// File: design/banked_work_ram_address_decoder_core_assert.svh
// assertion macros for the banked work ram address decoder
`ifndef BANKED_WORK_RAM_ADDRESS_DECODER_CORE_ASSERT_SVH
`define BANKED_WORK_RAM_ADDRESS_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BWAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bwad check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BWAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bwad check failed");

`endif

// File: design/bwad_pkg.sv
// shared types, constants and power-on tables of the banked work ram address decoder
`default_nettype none

package bwad_pkg;

  localparam int unsigned WRAM_BANKS_DEF = 8;
  localparam int unsigned BANK_BYTES     = 4096;
  localparam int unsigned HIGH_BYTES     = 127;
  localparam int unsigned OFF_W          = $clog2(BANK_BYTES);
  localparam int unsigned HIDX_W         = $clog2(HIGH_BYTES);

  localparam logic [15:0] BANK_REG_ADDR  = 16'hFF70;
  localparam logic [2:0]  BANK_MASK      = 3'h7;
  localparam logic [7:0]  BANK_READ_SET  = 8'hF8;
  localparam logic [7:0]  IDLE_BYTE      = 8'hFF;
  localparam logic [15:0] WRAM_BASE      = 16'hC000;
  localparam logic [15:0] WRAM_FIXED_END = 16'hCFFF;
  localparam logic [15:0] CART_ROM_END   = 16'h7FFF;
  localparam logic [15:0] VRAM_END       = 16'h9FFF;
  localparam logic [15:0] CART_RAM_END   = 16'hBFFF;
  localparam logic [15:0] ECHO_END       = 16'hFDFF;
  localparam logic [15:0] OAM_END        = 16'hFE9F;
  localparam logic [15:0] HRAM_BASE      = 16'hFF80;
  localparam logic [15:0] HRAM_END       = 16'hFFFE;

  // register index decoded from paddr[2]
  localparam logic REG_COLOR_MODE = 1'b0;

  typedef enum logic [2:0] {
    ROUTE_INTERNAL = 3'd0,
    ROUTE_CART_ROM = 3'd1,
    ROUTE_VRAM     = 3'd2,
    ROUTE_OAM      = 3'd3,
    ROUTE_CART_RAM = 3'd4,
    ROUTE_UNMAPPED = 3'd5
  } route_e;

  // decode of one access, handed from the decoder to the top level
  typedef struct packed {
    route_e            route;
    logic              ext;
    logic              wram;
    logic              hram;
    logic              bank_wr;
    logic [2:0]        bank_next;
    logic [7:0]        direct_byte;
    logic [HIDX_W-1:0] hram_idx;
  } dec_t;

  localparam logic [7:0] HRAM_MONO [HIGH_BYTES] = '{
    8'h2B, 8'h0B, 8'h64, 8'h2F, 8'hAF, 8'h15, 8'h60, 8'h6D,
    8'h61, 8'h4E, 8'hAC, 8'h45, 8'h0F, 8'hDA, 8'h92, 8'hF3,
    8'h83, 8'h38, 8'hE4, 8'h4E, 8'hA7, 8'h6C, 8'h38, 8'h58,
    8'hBE, 8'hEA, 8'hE5, 8'h81, 8'hB4, 8'hCB, 8'hBF, 8'h7B,
    8'h59, 8'hAD, 8'h50, 8'h13, 8'h5E, 8'hF6, 8'hB3, 8'hC1,
    8'hDC, 8'hDF, 8'h9E, 8'h68, 8'hD7, 8'h59, 8'h26, 8'hF3,
    8'h62, 8'h54, 8'hF8, 8'h36, 8'hB7, 8'h78, 8'h6A, 8'h22,
    8'hA7, 8'hDD, 8'h88, 8'h15, 8'hCA, 8'h96, 8'h39, 8'hD3,
    8'hE6, 8'h55, 8'h6E, 8'hEA, 8'h90, 8'h76, 8'hB8, 8'hFF,
    8'h50, 8'hCD, 8'hB5, 8'h1B, 8'h1F, 8'hA5, 8'h4D, 8'h2E,
    8'hB4, 8'h09, 8'h47, 8'h8A, 8'hC4, 8'h5A, 8'h8C, 8'h4E,
    8'hE7, 8'h29, 8'h50, 8'h88, 8'hA8, 8'h66, 8'h85, 8'h4B,
    8'hAA, 8'h38, 8'hE7, 8'h6B, 8'h45, 8'h3E, 8'h30, 8'h37,
    8'hBA, 8'hC5, 8'h31, 8'hF2, 8'h71, 8'hB4, 8'hCF, 8'h29,
    8'hBC, 8'h7F, 8'h7E, 8'hD0, 8'hC7, 8'hC3, 8'hBD, 8'hCF,
    8'h59, 8'hEA, 8'h39, 8'h01, 8'h2E, 8'h00, 8'h69
  };

  localparam logic [7:0] HRAM_COLOR [HIGH_BYTES] = '{
    8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
    8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
    8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
    8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
    8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
    8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
    8'h45, 8'hEC, 8'h42, 8'hFA, 8'h08, 8'hB7, 8'h07, 8'h5D,
    8'h01, 8'hF5, 8'hC0, 8'hFF, 8'h08, 8'hFC, 8'h00, 8'hE5,
    8'h0B, 8'hF8, 8'hC2, 8'hCA, 8'hF4, 8'hF9, 8'h0D, 8'h7F,
    8'h44, 8'h6D, 8'h19, 8'hFE, 8'h46, 8'h97, 8'h33, 8'h5E,
    8'h08, 8'hFF, 8'hD1, 8'hFF, 8'hC6, 8'h8B, 8'h24, 8'h74,
    8'h12, 8'hFC, 8'h00, 8'h9F, 8'h94, 8'hB7, 8'h06, 8'hD5,
    8'h40, 8'h7A, 8'h20, 8'h9E, 8'h04, 8'h5F, 8'h41, 8'h2F,
    8'h3D, 8'h77, 8'h36, 8'h75, 8'h81, 8'h8A, 8'h70, 8'h3A,
    8'h98, 8'hD1, 8'h71, 8'h02, 8'h4D, 8'h01, 8'hC1, 8'hFF,
    8'h0D, 8'h00, 8'hD3, 8'h05, 8'hF9, 8'h00, 8'h0B
  };

endpackage

`default_nettype wire

// File: design/bwad_decode.sv
// address decode, echo fold and work ram bank mapping of one access
`default_nettype none

module bwad_decode #(
  parameter int unsigned WramBanks = bwad_pkg::WRAM_BANKS_DEF,
  parameter int unsigned WramAw    = 15
) (
  input  logic              cmd_i,
  input  logic [15:0]       addr_i,
  input  logic [7:0]        wdata_i,
  input  logic              color_mode_i,
  input  logic [2:0]        bank_i,
  output bwad_pkg::dec_t    dec_o,
  output logic [WramAw-1:0] wram_idx_o
);
  import bwad_pkg::*;

  localparam int unsigned BankW = WramAw - OFF_W;

  logic [3:0] bank_num;

  // bank for d000-dfff: wrap beyond the bank count, zero becomes one
  always_comb begin
    bank_num = {1'b0, (color_mode_i ? bank_i : 3'd1)};
    for (int k = 0; k < 3; k++) begin
      if (bank_num >= 4'(WramBanks)) begin
        bank_num = bank_num - 4'(WramBanks);
      end
    end
    if (bank_num == 4'd0) begin
      bank_num = 4'd1;
    end
  end

  // echo space keeps the low 13 bits, so bit 12 picks fixed or switched bank
  assign wram_idx_o = addr_i[OFF_W] ? {bank_num[BankW-1:0], addr_i[OFF_W-1:0]}
                                    : {BankW'(0), addr_i[OFF_W-1:0]};

  always_comb begin
    dec_o             = '0;
    dec_o.route       = ROUTE_INTERNAL;
    dec_o.direct_byte = IDLE_BYTE;
    dec_o.hram_idx    = addr_i[HIDX_W-1:0];
    dec_o.bank_next   = ((wdata_i[2:0] & BANK_MASK) == 3'd0) ? 3'd1 : (wdata_i[2:0] & BANK_MASK);
    if (addr_i <= CART_ROM_END) begin
      dec_o.route = ROUTE_CART_ROM;
      dec_o.ext   = 1'b1;
    end else if (addr_i <= VRAM_END) begin
      dec_o.route = ROUTE_VRAM;
      dec_o.ext   = 1'b1;
    end else if (addr_i <= CART_RAM_END) begin
      dec_o.route = ROUTE_CART_RAM;
      dec_o.ext   = 1'b1;
    end else if (addr_i <= ECHO_END) begin
      dec_o.wram  = (addr_i >= WRAM_BASE);
    end else if (addr_i <= OAM_END) begin
      dec_o.route = ROUTE_OAM;
      dec_o.ext   = 1'b1;
    end else if (addr_i >= HRAM_BASE && addr_i <= HRAM_END) begin
      dec_o.hram  = 1'b1;
    end else if (addr_i == BANK_REG_ADDR) begin
      dec_o.bank_wr = cmd_i && color_mode_i;
      if (!cmd_i && color_mode_i) begin
        dec_o.direct_byte = BANK_READ_SET | {5'd0, (bank_i & BANK_MASK)};
      end
    end else begin
      dec_o.route = ROUTE_UNMAPPED;
    end
  end

endmodule

`default_nettype wire

// File: design/bwad_wram.sv
// banked work ram store with a zero sweep after reset
`default_nettype none

module bwad_wram #(
  parameter int unsigned WramBanks = bwad_pkg::WRAM_BANKS_DEF,
  parameter int unsigned WramAw    = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic              we_i,
  input  logic [WramAw-1:0] idx_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o,
  output logic              clearing_o
);
  import bwad_pkg::*;

  localparam int unsigned Depth = WramBanks * BANK_BYTES;
  localparam logic [WramAw-1:0] LastIdx = WramAw'(Depth - 1);

  logic [7:0]        mem [Depth];
  logic [7:0]        rd_q;
  logic              clr_q, clr_d;
  logic [WramAw-1:0] cnt_q, cnt_d;

  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + WramAw'(1);
      if (cnt_q == LastIdx) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  // single port: sweep write, item write or item read
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[cnt_q] <= 8'd0;
    end else if (acc_i && we_i) begin
      mem[idx_i] <= wdata_i;
    end else if (acc_i) begin
      rd_q <= mem[idx_i];
    end
  end

  assign rdata_o    = rd_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

// File: design/bwad_hram.sv
// high ram store with written bits over the power-on tables
`default_nettype none

module bwad_hram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        color_mode_i,
  input  logic                        reload_i,
  input  logic                        acc_i,
  input  logic                        we_i,
  input  logic [bwad_pkg::HIDX_W-1:0] idx_i,
  input  logic [7:0]                  wdata_i,
  output logic [7:0]                  rdata_o
);
  import bwad_pkg::*;

  logic [7:0]            mem [HIGH_BYTES];
  logic [HIGH_BYTES-1:0] vld_q;
  logic [7:0]            rd_q;
  logic                  rd_vld_q;
  logic [HIDX_W-1:0]     rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (reload_i) begin
      vld_q <= '0;
    end else if (acc_i && we_i) begin
      vld_q[idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && we_i) begin
      mem[idx_i] <= wdata_i;
    end else if (acc_i) begin
      rd_q     <= mem[idx_i];
      rd_vld_q <= vld_q[idx_i];
      rd_idx_q <= idx_i;
    end
  end

  // unwritten entries read the power-on table of the current mode
  always_comb begin
    if (rd_vld_q) begin
      rdata_o = rd_q;
    end else if (color_mode_i) begin
      rdata_o = HRAM_COLOR[rd_idx_q];
    end else begin
      rdata_o = HRAM_MONO[rd_idx_q];
    end
  end

endmodule

`default_nettype wire

// File: design/banked_work_ram_address_decoder_core.sv
// top level: decode stage, memory read stage and output register of the decoder
// throughput: one item per cycle once the reset sweep is done while results are taken
// a waiting result lets one more item into the read stage, then the input stalls
// an accepted item passes the stage-one register, then the output register, where the result can be taken
// reset: work ram zeroed by a sweep over all WramBanks*4096 entries, high ram on monochrome table
// a colour mode write reloads high ram and sets the bank to one in the same cycle
`default_nettype none
`include "banked_work_ram_address_decoder_core_assert.svh"

module banked_work_ram_address_decoder_core #(
  parameter int unsigned WramBanks = bwad_pkg::WRAM_BANKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_byte_o,
  output logic [2:0]  route_o,
  output logic [15:0] ext_address_o,
  output logic        ext_write_o,
  output logic [7:0]  ext_data_o,
  output logic        unmapped_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bwad_pkg::*;

  // bank bits of the work ram index, at least one
  localparam int unsigned BankW  = (WramBanks > 1) ? $clog2(WramBanks) : 1;
  localparam int unsigned WramAw = BankW + OFF_W;

  // where the read byte of a stage-one item comes from
  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_WRAM,
    SRC_HRAM
  } src_e;

  // configuration and bank register
  logic       color_q;
  logic [2:0] bank_q;
  logic       cfg_wr;

  // decode outputs
  dec_t              dec;
  logic [WramAw-1:0] wram_idx;

  // memory side
  logic [7:0] wram_rdata;
  logic [7:0] hram_rdata;
  logic       wram_clearing;

  // handshake
  logic accept;
  logic out_adv;
  logic s1_adv;

  // stage one: memory read in flight
  logic        s1_valid_q;
  logic        s1_cmd_q;
  src_e        s1_src_q;
  route_e      s1_route_q;
  logic        s1_ext_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_wdata_q;
  logic [7:0]  s1_direct_q;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_read_q;
  logic [2:0]  out_route_q;
  logic [15:0] out_addr_q;
  logic        out_ext_wr_q;
  logic [7:0]  out_ext_data_q;
  logic        out_unmapped_q;
  logic [7:0]  s1_read_byte;

  // register port: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COLOR_MODE);
  assign prdata = (paddr[2] == REG_COLOR_MODE) ? {31'd0, color_q} : 32'd0;

  // stage one moves on when the output register is free or being drained
  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_ready_o = !wram_clearing && (!s1_valid_q || out_adv);
  assign accept     = in_valid_i && in_ready_o;

  bwad_decode #(
    .WramBanks (WramBanks),
    .WramAw    (WramAw)
  ) u_decode (
    .cmd_i        (cmd_i),
    .addr_i       (bus_address_i),
    .wdata_i      (write_byte_i),
    .color_mode_i (color_q),
    .bank_i       (bank_q),
    .dec_o        (dec),
    .wram_idx_o   (wram_idx)
  );

  // memories are read or written at the accepting edge, so later items see the write
  bwad_wram #(
    .WramBanks (WramBanks),
    .WramAw    (WramAw)
  ) u_wram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept && dec.wram),
    .we_i       (cmd_i),
    .idx_i      (wram_idx),
    .wdata_i    (write_byte_i),
    .rdata_o    (wram_rdata),
    .clearing_o (wram_clearing)
  );

  bwad_hram u_hram (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_mode_i (color_q),
    .reload_i     (cfg_wr),
    .acc_i        (accept && dec.hram),
    .we_i         (cmd_i),
    .idx_i        (dec.hram_idx),
    .wdata_i      (write_byte_i),
    .rdata_o      (hram_rdata)
  );

  // colour mode and bank register; a mode write puts the bank back to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= 1'b0;
      bank_q  <= 3'd1;
    end else if (cfg_wr) begin
      color_q <= pwdata[0];
      bank_q  <= 3'd1;
    end else if (accept && dec.bank_wr) begin
      bank_q  <= dec.bank_next;
    end
  end

  // control of the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage one payload, loaded with the decode of the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= cmd_i;
      s1_route_q  <= dec.route;
      s1_ext_q    <= dec.ext;
      s1_addr_q   <= bus_address_i;
      s1_wdata_q  <= write_byte_i;
      s1_direct_q <= dec.direct_byte;
      if (dec.wram) begin
        s1_src_q <= SRC_WRAM;
      end else if (dec.hram) begin
        s1_src_q <= SRC_HRAM;
      end else begin
        s1_src_q <= SRC_DIRECT;
      end
    end
  end

  // read byte: writes always give the idle byte
  always_comb begin
    case (s1_src_q)
      SRC_WRAM: s1_read_byte = wram_rdata;
      SRC_HRAM: s1_read_byte = hram_rdata;
      default:  s1_read_byte = s1_direct_q;
    endcase
    if (s1_cmd_q) begin
      s1_read_byte = IDLE_BYTE;
    end
  end

  // output register, parts the result side from the memory read
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_read_q     <= s1_read_byte;
      out_route_q    <= s1_route_q;
      out_addr_q     <= s1_ext_q ? s1_addr_q : 16'd0;
      out_ext_wr_q   <= s1_ext_q && s1_cmd_q;
      out_ext_data_q <= (s1_ext_q && s1_cmd_q) ? s1_wdata_q : 8'd0;
      out_unmapped_q <= (s1_route_q == ROUTE_UNMAPPED);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_byte_o   = out_read_q;
  assign route_o       = out_route_q;
  assign ext_address_o = out_addr_q;
  assign ext_write_o   = out_ext_wr_q;
  assign ext_data_o    = out_ext_data_q;
  assign unmapped_o    = out_unmapped_q;

  // no item enters while the work ram sweep owns the port
  `BWAD_ASSERT_NOW(no_accept_in_sweep_a, in_valid_i && in_ready_o, !wram_clearing)
  // a stalled stage one keeps its item
  `BWAD_ASSERT_NEXT(s1_hold_a, s1_valid_q && !out_adv, s1_valid_q)
  // the bank register never holds zero
  `BWAD_ASSERT_NOW(bank_nonzero_a, 1'b1, bank_q != 3'd0)
  // an unmapped result carries the unmapped route and no external write
  `BWAD_ASSERT_NOW(unmapped_route_a, out_valid_o && unmapped_o, (route_o == ROUTE_UNMAPPED) && !ext_write_o)

endmodule

`default_nettype wire
